// ----- hdl/wcse_pkg.sv -----
// ----------------------------------------------------------------------------
// wcse_pkg
// Shared types and constants for the wheel counter to scroll events block.
// ----------------------------------------------------------------------------
`default_nettype none

package wcse_pkg;

  localparam int unsigned RepMax    = 128;
  localparam int unsigned NumSlots  = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;

  typedef enum logic [2:0] {
    EvFourth = 3'd0,
    EvLeft   = 3'd1,
    EvRight  = 3'd2,
    EvUp     = 3'd3,
    EvDown   = 3'd4
  } event_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgReverseBoth  = 3'd0,
    CfgReverseX     = 3'd1,
    CfgReverseY     = 3'd2,
    CfgModSwapMask  = 3'd3,
    CfgBtnSwapMask  = 3'd4,
    CfgLeftFourth   = 3'd5,
    CfgRightFourth  = 3'd6,
    CfgButtonScroll = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic       reverse_both;
    logic       reverse_x;
    logic       reverse_y;
    logic [7:0] modifier_swap_mask;
    logic [5:0] button_swap_mask;
    logic       left_fourth_enable;
    logic       right_fourth_enable;
    logic       button_scroll_enable;
  } cfg_t;

  // slots in result order: left fourth, wheel left, right fourth, wheel right,
  // horizontal wheel, vertical wheel
  typedef struct packed {
    logic [NumSlots-1:0] slot_mask;
    logic                x_neg;
    logic                y_neg;
    logic [7:0]          x_cnt;
    logic [7:0]          y_cnt;
  } tick_rec_t;

endpackage

`default_nettype wire

// ----- hdl/wcse_front.sv -----
// ----------------------------------------------------------------------------
// wcse_front
// Takes one tick, forms wheel deltas and spare button edges, and writes
// a record of the results it causes into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wcse_front #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wcse_pkg::cfg_t      cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          count_x_i,
  input  wire logic [7:0]          count_y_i,
  input  wire logic [7:0]          port_a_bits_i,
  input  wire logic [7:0]          pot_bits_i,
  input  wire logic [7:0]          key_qualifiers_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output wcse_pkg::tick_rec_t      q_data_o
);

  localparam int unsigned CB = COUNTER_BITS;
  localparam int unsigned MW = COUNTER_BITS + 8;

  logic [CB-1:0] prev_x_q, prev_x_d;
  logic [CB-1:0] prev_y_q, prev_y_d;
  logic          primed_q, primed_d;
  logic          prev_left_q, prev_left_d;
  logic          prev_right_q, prev_right_d;

  logic [MW-1:0] ext_x, ext_y;
  logic [CB-1:0] cur_x, cur_y;
  logic [CB-1:0] dx, dy;
  logic [CB-1:0] mag_x, mag_y;
  logic [7:0]    cnt_x, cnt_y;
  logic          nz_x, nz_y, neg_x, neg_y;
  logic          hx_nz, hy_nz, hx_neg, hy_neg;
  logic [7:0]    hx_cnt, hy_cnt;
  logic [5:0]    pressed;
  logic          swap;
  logic          left_en, right_en, left_fall, right_fall;
  logic          accept;
  logic [wcse_pkg::NumSlots-1:0] mask;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign ext_x = MW'(count_x_i);
  assign ext_y = MW'(count_y_i);
  assign cur_x = ext_x[CB-1:0];
  assign cur_y = ext_y[CB-1:0];

  always_comb begin
    dx    = cur_x - prev_x_q;
    dy    = cur_y - prev_y_q;
    neg_x = dx[CB-1];
    neg_y = dy[CB-1];
    nz_x  = |dx;
    nz_y  = |dy;
    mag_x = neg_x ? (~dx + CB'(1)) : dx;
    mag_y = neg_y ? (~dy + CB'(1)) : dy;
    cnt_x = (MW'(mag_x) > MW'(wcse_pkg::RepMax)) ? 8'(wcse_pkg::RepMax) : 8'(MW'(mag_x));
    cnt_y = (MW'(mag_y) > MW'(wcse_pkg::RepMax)) ? 8'(wcse_pkg::RepMax) : 8'(MW'(mag_y));
  end

  always_comb begin
    pressed = {~pot_bits_i[6], ~pot_bits_i[4], ~pot_bits_i[2], ~pot_bits_i[0],
               ~port_a_bits_i[7], ~port_a_bits_i[6]};
    swap = (|(key_qualifiers_i & cfg_i.modifier_swap_mask))
        || (|(pressed & cfg_i.button_swap_mask));
    // sign flips only; magnitudes ride along with the swap
    if (swap) begin
      hx_nz  = nz_y;
      hy_nz  = nz_x;
      hx_neg = neg_y ^ cfg_i.reverse_both ^ cfg_i.reverse_x;
      hy_neg = neg_x ^ cfg_i.reverse_both ^ cfg_i.reverse_y;
      hx_cnt = cnt_y;
      hy_cnt = cnt_x;
    end else begin
      hx_nz  = nz_x;
      hy_nz  = nz_y;
      hx_neg = neg_x ^ cfg_i.reverse_both ^ cfg_i.reverse_x;
      hy_neg = neg_y ^ cfg_i.reverse_both ^ cfg_i.reverse_y;
      hx_cnt = cnt_x;
      hy_cnt = cnt_y;
    end
  end

  assign left_en    = cfg_i.left_fourth_enable || cfg_i.button_scroll_enable;
  assign right_en   = cfg_i.right_fourth_enable || cfg_i.button_scroll_enable;
  assign left_fall  = left_en && prev_left_q && !port_a_bits_i[7];
  assign right_fall = right_en && prev_right_q && !pot_bits_i[6];

  always_comb begin
    mask = {hy_nz, hx_nz,
            right_fall && cfg_i.button_scroll_enable,
            right_fall && cfg_i.right_fourth_enable,
            left_fall && cfg_i.button_scroll_enable,
            left_fall && cfg_i.left_fourth_enable};
    q_data_o.slot_mask = mask;
    q_data_o.x_neg     = hx_neg;
    q_data_o.y_neg     = hy_neg;
    q_data_o.x_cnt     = hx_cnt;
    q_data_o.y_cnt     = hy_cnt;
    q_push_o           = accept && primed_q && (|mask);
  end

  always_comb begin
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    primed_d     = primed_q;
    prev_left_d  = prev_left_q;
    prev_right_d = prev_right_q;
    if (accept) begin
      prev_x_d = cur_x;
      prev_y_d = cur_y;
      primed_d = 1'b1;
      // first tick leaves spare history alone
      if (primed_q) begin
        if (left_en) begin
          prev_left_d = port_a_bits_i[7];
        end
        if (right_en) begin
          prev_right_d = pot_bits_i[6];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      primed_q     <= 1'b0;
      prev_left_q  <= 1'b0;
      prev_right_q <= 1'b0;
    end else begin
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      primed_q     <= primed_d;
      prev_left_q  <= prev_left_d;
      prev_right_q <= prev_right_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wcse_queue.sv -----
// ----------------------------------------------------------------------------
// wcse_queue
// Two-entry queue of tick records between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wcse_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire wcse_pkg::tick_rec_t push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output wcse_pkg::tick_rec_t      head_o
);

  localparam int unsigned Depth = 2;

  wcse_pkg::tick_rec_t mem_q [Depth];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;

  assign full_o  = (count_q == 2'(Depth));
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wcse_back.sv -----
// ----------------------------------------------------------------------------
// wcse_back
// Drains one tick record at a time, one result per cycle while out_ready_i
// does not stall the output register, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wcse_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire wcse_pkg::tick_rec_t q_head_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               event_code_o,
  output logic [7:0]               repeat_count_o,
  output logic                     last_of_tick_o
);

  localparam int unsigned NS = wcse_pkg::NumSlots;

  logic [NS-1:0]       cur_q, cur_d;
  wcse_pkg::tick_rec_t rec_q;
  logic [NS-1:0]       sel, rest;
  logic                emit;
  logic                out_valid_q, out_valid_d;
  wcse_pkg::event_code_e code_q, code;
  logic [7:0]          cnt_q, cnt;
  logic                last_q;

  always_comb begin
    sel  = cur_q & (~cur_q + NS'(1));
    rest = cur_q & ~sel;
    emit = (|cur_q) && (!out_valid_q || out_ready_i);
    // reload as soon as the current record has no slots left
    q_pop_o = q_valid_i && (!(|cur_q) || (emit && !(|rest)));
    if (q_pop_o) begin
      cur_d = q_head_i.slot_mask;
    end else if (emit) begin
      cur_d = rest;
    end else begin
      cur_d = cur_q;
    end
  end

  always_comb begin
    code = wcse_pkg::EvFourth;
    cnt  = 8'd1;
    if (sel[1]) begin
      code = wcse_pkg::EvLeft;
    end else if (sel[3]) begin
      code = wcse_pkg::EvRight;
    end else if (sel[4]) begin
      code = rec_q.x_neg ? wcse_pkg::EvRight : wcse_pkg::EvLeft;
      cnt  = rec_q.x_cnt;
    end else if (sel[5]) begin
      code = rec_q.y_neg ? wcse_pkg::EvDown : wcse_pkg::EvUp;
      cnt  = rec_q.y_cnt;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q <= q_head_i;
    end
    if (emit) begin
      code_q <= code;
      cnt_q  <= cnt;
      last_q <= !(|rest);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_code_o   = code_q;
  assign repeat_count_o = cnt_q;
  assign last_of_tick_o = last_q;

endmodule

`default_nettype wire

// ----- hdl/wheel_counter_to_scroll_events.sv -----
// a tick is written to the queue, loaded into the back end, then registered at the output
// throughput: one result per cycle while out_ready_i does not stall the output
// input side stalls only when the two-entry record queue is full
// reset: configuration clears to zero, the first tick after reset only loads the counters
// ----------------------------------------------------------------------------
// wheel_counter_to_scroll_events_core
// Turns per-frame wheel counter samples and button bytes into scroll events.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_counter_to_scroll_events_core #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] count_x_i,
  input  wire logic [7:0] count_y_i,
  input  wire logic [7:0] port_a_bits_i,
  input  wire logic [7:0] pot_bits_i,
  input  wire logic [7:0] key_qualifiers_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      event_code_o,
  output logic [7:0]      repeat_count_o,
  output logic            last_of_tick_o
);

  wcse_pkg::cfg_t      cfg_q, cfg_d;
  wcse_pkg::tick_rec_t push_data, head;
  logic                push, full, pop, q_valid;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (wcse_pkg::cfg_idx_e'(cfg_index_i))
        wcse_pkg::CfgReverseBoth:  cfg_d.reverse_both         = cfg_data_i[0];
        wcse_pkg::CfgReverseX:     cfg_d.reverse_x            = cfg_data_i[0];
        wcse_pkg::CfgReverseY:     cfg_d.reverse_y            = cfg_data_i[0];
        wcse_pkg::CfgModSwapMask:  cfg_d.modifier_swap_mask   = cfg_data_i;
        wcse_pkg::CfgBtnSwapMask:  cfg_d.button_swap_mask     = cfg_data_i[5:0];
        wcse_pkg::CfgLeftFourth:   cfg_d.left_fourth_enable   = cfg_data_i[0];
        wcse_pkg::CfgRightFourth:  cfg_d.right_fourth_enable  = cfg_data_i[0];
        wcse_pkg::CfgButtonScroll: cfg_d.button_scroll_enable = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wcse_front #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .count_x_i        (count_x_i),
    .count_y_i        (count_y_i),
    .port_a_bits_i    (port_a_bits_i),
    .pot_bits_i       (pot_bits_i),
    .key_qualifiers_i (key_qualifiers_i),
    .q_full_i         (full),
    .q_push_o         (push),
    .q_data_o         (push_data)
  );

  wcse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  wcse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (head),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_code_o   (event_code_o),
    .repeat_count_o (repeat_count_o),
    .last_of_tick_o (last_of_tick_o)
  );

endmodule

`default_nettype wire
